// File: src/rbd_pkg.sv
package rbd_pkg;

  // Default sizes of the queue storage.
  localparam int DepthDef     = 16;
  localparam int DataWidthDef = 32;

  // Fixed field widths on the stream ports.
  localparam int FuncW   = 3;
  localparam int ValueW  = 32;
  localparam int IndexW  = 5;
  localparam int DataW   = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 5;

  // Input word: value in the low bits, then index, padded to whole bytes.
  localparam int InDataW  = 40;
  // Output word: data, status, count, padded to whole bytes.
  localparam int OutDataW = 40;

  typedef enum logic [FuncW-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_READ       = 3'd4,
    FN_CLEAR      = 3'd5
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Result of one operation, carried alongside the memory read.
  typedef struct packed {
    logic              rd;
    status_e           status;
    logic [CountW-1:0] count;
  } rbd_res_t;

endpackage

// File: src/rbd_ram.sv
module rbd_ram
  import rbd_pkg::*;
#(
  parameter int Width = DataWidthDef,
  parameter int Depth = DepthDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single port: one write, one registered read, or both per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rbd_ctrl.sv
module rbd_ctrl
  import rbd_pkg::*;
#(
  parameter int Depth     = DepthDef,
  parameter int DataWidth = DataWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [FuncW-1:0]         func_i,
  input  logic [ValueW-1:0]        value_i,
  input  logic signed [IndexW-1:0] index_i,
  output logic                     ram_we_o,
  output logic                     ram_re_o,
  output logic [$clog2(Depth)-1:0] ram_addr_o,
  output logic [DataWidth-1:0]     ram_wdata_o,
  output rbd_res_t                 res_o
);

  localparam int AddrW = $clog2(Depth);
  localparam int OccW  = $clog2(Depth + 1);
  localparam int PosW  = ((OccW > IndexW) ? OccW : IndexW) + 1;

  logic [AddrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [OccW-1:0]  occ_q, occ_d;

  logic [AddrW-1:0]       head_dec, tail_inc, tail_dec, head_inc;
  logic                   full, empty;
  logic signed [PosW-1:0] idx_ext, occ_ext, pos;
  logic                   pos_bad;
  logic [AddrW:0]         rd_sum, rd_wrap;
  status_e                status;
  logic                   rd;

  // Pointer steps with wrap at the configured depth.
  assign head_dec = (head_q == '0) ? AddrW'(Depth - 1) : head_q - 1'b1;
  assign head_inc = (head_q == AddrW'(Depth - 1)) ? '0 : head_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? AddrW'(Depth - 1) : tail_q - 1'b1;
  assign tail_inc = (tail_q == AddrW'(Depth - 1)) ? '0 : tail_q + 1'b1;

  assign full  = (occ_q == OccW'(Depth));
  assign empty = (occ_q == '0);

  // Indexed read position: a negative index counts back from the end.
  assign idx_ext = PosW'(index_i);
  assign occ_ext = signed'(PosW'(occ_q));
  assign pos     = (idx_ext < 0) ? idx_ext + occ_ext : idx_ext;
  assign pos_bad = (pos < 0) || (pos >= occ_ext);
  assign rd_sum  = {1'b0, head_q} + pos[AddrW:0];
  assign rd_wrap = (rd_sum >= (AddrW + 1)'(Depth)) ? rd_sum - (AddrW + 1)'(Depth) : rd_sum;

  // Operation decode: next pointers, memory request and status.
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = head_q;
    ram_wdata_o = DataWidth'(value_i);
    status      = ST_OK;
    rd          = 1'b0;
    unique case (func_i)
      FN_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          head_d     = head_dec;
          ram_addr_o = head_dec;
          ram_we_o   = en_i;
          occ_d      = occ_q + 1'b1;
        end
      end
      FN_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ram_addr_o = tail_q;
          tail_d     = tail_inc;
          ram_we_o   = en_i;
          occ_d      = occ_q + 1'b1;
        end
      end
      FN_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ram_addr_o = head_q;
          head_d     = head_inc;
          ram_re_o   = en_i;
          rd         = 1'b1;
          occ_d      = occ_q - 1'b1;
        end
      end
      FN_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          tail_d     = tail_dec;
          ram_addr_o = tail_dec;
          ram_re_o   = en_i;
          rd         = 1'b1;
          occ_d      = occ_q - 1'b1;
        end
      end
      FN_READ: begin
        if (pos_bad) begin
          status = ST_RANGE;
        end else begin
          ram_addr_o = rd_wrap[AddrW-1:0];
          ram_re_o   = en_i;
          rd         = 1'b1;
        end
      end
      FN_CLEAR: begin
        head_d = '0;
        tail_d = '0;
        occ_d  = '0;
      end
      default: begin
      end
    endcase
  end

  assign res_o.rd     = rd;
  assign res_o.status = status;
  assign res_o.count  = CountW'(occ_d);

  // Pointer and occupancy registers advance on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
    end else if (en_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
    end
  end

endmodule

// File: src/ring_buffer_deque.sv
// Channel   Direction  Word contents
// s_axis    in         tuser: func; tdata: value, index
// m_axis    out        tdata: data, status, count
//
// Each operation: the pointers update and the storage RAM is written or read in
// the accept cycle; the result waits in the pending stage, and the registered RAM
// read data joins it in the result register when the pending stage moves on.
// With m_axis_tready high, one word is accepted every cycle.
// Reset clears head, tail and occupancy; the storage RAM is not cleared.
// A stalled result holds the pending stage; input is refused while that stage is full.
module ring_buffer_deque
  import rbd_pkg::*;
#(
  parameter int DEPTH      = DepthDef,
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // value[31:0], index[36:32], zero pad
  input  logic [FuncW-1:0]    s_axis_tuser,  // func[2:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // data[31:0], status[33:32], count[38:34]
);

  localparam int AddrW = $clog2(DEPTH);

  logic                  accept, pend_move;
  logic                  ram_we, ram_re;
  logic [AddrW-1:0]      ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  rbd_res_t              res;

  logic                  pend_q, pend_d;
  rbd_res_t              pend_res_q;
  logic                  out_valid_q, out_valid_d;
  logic [DataW-1:0]      out_data_q;
  rbd_res_t              out_res_q;

  // Input handshake: the pending stage must be free or moving on.
  assign pend_move     = pend_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !pend_q || pend_move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rbd_ctrl #(
    .Depth    (DEPTH),
    .DataWidth(DATA_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (accept),
    .func_i     (s_axis_tuser),
    .value_i    (s_axis_tdata[ValueW-1:0]),
    .index_i    (signed'(s_axis_tdata[ValueW+IndexW-1:ValueW])),
    .ram_we_o   (ram_we),
    .ram_re_o   (ram_re),
    .ram_addr_o (ram_addr),
    .ram_wdata_o(ram_wdata),
    .res_o      (res)
  );

  rbd_ram #(
    .Width(DATA_WIDTH),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Valid flags of the pending and output stages.
  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b1;
    end else if (pend_move) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (pend_move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers; the RAM read data joins the result here.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_res_q <= res;
    end
    if (pend_move) begin
      out_res_q  <= pend_res_q;
      out_data_q <= pend_res_q.rd ? DataW'(ram_rdata) : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q.count, out_res_q.status, out_data_q};

  // A word accepted always occupies the pending stage next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pend_q)
    else $error("accepted word did not reach the pending stage");

  // The single-port RAM is never asked to read and write at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("RAM read and write in the same cycle");

  // A full status comes only with a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_res_q.status == ST_FULL))
      |-> (out_res_q.count == CountW'(DEPTH)))
    else $error("full status with a queue that is not full");

  // An empty status comes only with an empty queue and no data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_res_q.status == ST_EMPTY))
      |-> ((out_res_q.count == '0) && (out_data_q == '0)))
    else $error("empty status with elements held or data returned");

endmodule

// File: dv/ring_buffer_deque_test.sv
`timescale 1ns / 100ps

module ring_buffer_deque_test;
  import rbd_pkg::*;

  localparam int Depth  = DepthDef;
  localparam int PtrW   = $clog2(Depth);
  localparam int HoldOffCycles = 80;
  localparam int PhaseItems    = 430;

  // Function codes the block treats as no operation.
  localparam logic [FuncW-1:0] FnSpare6 = 3'd6;
  localparam logic [FuncW-1:0] FnSpare7 = 3'd7;

  typedef struct {
    logic [DataW-1:0]  data;
    status_e           status;
    logic [CountW-1:0] count;
  } deque_result_t;

  // Tracks the deque contents and checks every result word in order.
  class deque_scoreboard;
    logic [DataW-1:0]  entries [Depth];
    logic [PtrW-1:0]   head_ptr;
    logic [PtrW-1:0]   tail_ptr;
    int                occupancy;
    deque_result_t     expected_q [$];
    int                errors;

    function new();
      head_ptr  = '0;
      tail_ptr  = '0;
      occupancy = 0;
      errors    = 0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Applies one accepted operation and queues the word it should produce.
    function void note_op(logic [FuncW-1:0] fn, logic [ValueW-1:0] val,
                          logic signed [IndexW-1:0] idx);
      deque_result_t r;
      int pos;
      r.data   = '0;
      r.status = ST_OK;
      case (fn)
        FN_PUSH_FRONT: begin
          if (occupancy >= Depth) begin
            r.status = ST_FULL;
          end else begin
            head_ptr = head_ptr - 1'b1;
            entries[head_ptr] = val;
            occupancy++;
          end
        end
        FN_PUSH_BACK: begin
          if (occupancy >= Depth) begin
            r.status = ST_FULL;
          end else begin
            entries[tail_ptr] = val;
            tail_ptr = tail_ptr + 1'b1;
            occupancy++;
          end
        end
        FN_POP_FRONT: begin
          if (occupancy == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.data = entries[head_ptr];
            head_ptr = head_ptr + 1'b1;
            occupancy--;
          end
        end
        FN_POP_BACK: begin
          if (occupancy == 0) begin
            r.status = ST_EMPTY;
          end else begin
            tail_ptr = tail_ptr - 1'b1;
            r.data = entries[tail_ptr];
            occupancy--;
          end
        end
        FN_READ: begin
          pos = int'(idx);
          if (pos < 0) pos += occupancy;
          if (pos < 0 || pos >= occupancy) begin
            r.status = ST_RANGE;
          end else begin
            r.data = entries[(int'(head_ptr) + pos) % Depth];
          end
        end
        FN_CLEAR: begin
          head_ptr  = '0;
          tail_ptr  = '0;
          occupancy = 0;
        end
        default: begin
        end
      endcase
      r.count = occupancy[CountW-1:0];
      expected_q.insert(expected_q.size(), r);
    endfunction

    // Compares one result word with the oldest expected result.
    function void check_word(logic [OutDataW-1:0] w);
      deque_result_t     exp_r;
      logic [DataW-1:0]  got_data;
      logic [StatusW-1:0] got_status;
      logic [CountW-1:0] got_count;
      got_data   = w[DataW-1:0];
      got_status = w[DataW +: StatusW];
      got_count  = w[DataW+StatusW +: CountW];
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected word data=%h status=%0d count=%0d",
                       got_data, got_status, got_count));
        return;
      end
      exp_r = expected_q[0];
      expected_q.delete(0);
      if (got_data !== exp_r.data || got_status !== exp_r.status ||
          got_count !== exp_r.count) begin
        flag($sformatf("expected data=%h status=%0d count=%0d, got data=%h status=%0d count=%0d",
                       exp_r.data, exp_r.status, exp_r.count,
                       got_data, got_status, got_count));
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // value[31:0], index[36:32], zero pad
  logic [FuncW-1:0]    s_axis_tuser = '0;   // func[2:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // data[31:0], status[33:32], count[38:34]

  deque_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int items_sent     = 0;

  ring_buffer_deque i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Reset is asserted from the start and released once; it is not asserted again.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin : result_sink
    int hold_served;
    int stall_left;
    hold_served = 0;
    stall_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        stall_left  = HoldOffCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every accepted result word goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
  end

  // Offers one word, waits for its acceptance, then idles at random.
  task automatic send_op(input logic [FuncW-1:0] fn, input logic [ValueW-1:0] val,
                         input logic signed [IndexW-1:0] idx);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-ValueW-IndexW){1'b0}}, idx, val};
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_op(fn, val, idx);
    items_sent++;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // A run of random operations with the given push and pop shares in percent.
  task automatic run_burst(input int n, input int push_pct, input int pop_pct);
    int r;
    int pos;
    logic [FuncW-1:0]  fn;
    logic [ValueW-1:0] val;
    logic [IndexW-1:0] idx;
    for (int k = 0; k < n; k++) begin
      r   = $urandom_range(99);
      val = $urandom();
      if ($urandom_range(9) == 0) val = $urandom_range(1) ? '1 : '0;
      idx = IndexW'($urandom());
      if (r < 2) begin
        fn = $urandom_range(1) ? FnSpare6 : FnSpare7;
      end else if (r < 3) begin
        fn = FN_CLEAR;
      end else if (r < 3 + push_pct) begin
        fn = $urandom_range(1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
      end else if (r < 3 + push_pct + pop_pct) begin
        fn = $urandom_range(1) ? FN_POP_FRONT : FN_POP_BACK;
      end else begin
        fn = FN_READ;
        // Mostly aim at held entries, from either end.
        if (sb.occupancy > 0 && $urandom_range(3) != 0) begin
          pos = $urandom_range(sb.occupancy - 1);
          if ($urandom_range(1)) pos -= sb.occupancy;
          idx = pos[IndexW-1:0];
        end
      end
      send_op(fn, val, idx);
    end
  endtask

  task automatic run_random_burst();
    case ($urandom_range(3))
      0: run_burst($urandom_range(8, 40), 75, 10);
      1: run_burst($urandom_range(8, 40), 10, 75);
      2: run_burst($urandom_range(8, 40), 40, 40);
      default: run_burst($urandom_range(8, 40), 20, 20);
    endcase
  endtask

  // Main sequence: directed corner cases, a fill with a result hold-off, then random phases of idling and stalls.
  initial begin : stimulus
    int target;
    int waited;
    deque_result_t left;
    do @(posedge clk_i); while (!rst_ni);

    // Empty queue: pops report empty, reads are out of range.
    send_op(FN_POP_FRONT, 32'h0, 5'sd0);
    send_op(FN_POP_BACK, 32'hFFFF_FFFF, -5'sd1);
    send_op(FN_READ, 32'h0, 5'sd0);
    // Extreme values pushed at both ends.
    send_op(FN_PUSH_BACK, 32'h0000_0000, 5'sd15);
    send_op(FN_PUSH_BACK, 32'hFFFF_FFFF, -5'sd16);
    send_op(FN_PUSH_FRONT, 32'h8000_0001, 5'sd0);
    send_op(FN_PUSH_FRONT, 32'h7FFF_FFFE, -5'sd1);
    // Reads from the front, from the back, inside, just outside on each side and at the index extremes.
    send_op(FN_READ, 32'h0, 5'sd0);
    send_op(FN_READ, 32'h0, -5'sd1);
    send_op(FN_READ, 32'h0, 5'sd2);
    send_op(FN_READ, 32'h0, -5'sd4);
    send_op(FN_READ, 32'h0, 5'sd4);
    send_op(FN_READ, 32'h0, -5'sd5);
    send_op(FN_READ, 32'h0, 5'sd15);
    send_op(FN_READ, 32'h0, -5'sd16);
    // Spare codes change nothing.
    send_op(FnSpare6, 32'hA5A5_A5A5, 5'sd7);
    send_op(FnSpare7, 32'h5A5A_5A5A, -5'sd8);
    send_op(FN_POP_FRONT, 32'h0, 5'sd0);
    send_op(FN_POP_BACK, 32'h0, 5'sd0);
    // Clear empties the queue even though entries are still held.
    send_op(FN_CLEAR, 32'h0, 5'sd0);
    send_op(FN_READ, 32'h0, -5'sd1);

    // Fill up, then hold off the result side while pushes keep coming.
    run_burst(20, 90, 0);
    hold_requests <= hold_requests + 1;
    run_burst(30, 75, 10);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 46;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 46;
        end
        default: begin
          send_idle_pct = 9;
          recv_stall_pct <= 9;
        end
      endcase
      target = items_sent + PhaseItems;
      while (items_sent < target) run_random_burst();
    end
    s_axis_tvalid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct <= 0;

    // Drain the remaining results, then allow the pipeline to settle.
    waited = 0;
    while (sb.expected_q.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    while (sb.expected_q.size() != 0) begin
      left = sb.expected_q[0];
      sb.expected_q.delete(0);
      sb.flag($sformatf("missing word data=%h status=%0d count=%0d",
                        left.data, left.status, left.count));
    end

    if (sb.errors == 0) begin
      $display("ring_buffer_deque_test: PASS");
    end else begin
      $display("ring_buffer_deque_test: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("ring_buffer_deque_test: FAIL");
    $finish;
  end

endmodule
